// ===== hdl/dis_pkg.sv =====
// shared types, constants and microcode program for the descending index selection sort
// no dependencies; used by dis_useq, the top level and dis_chk
`default_nettype none

package dis_pkg;

  localparam int IDX_W         = 5;
  localparam int KEY_W         = 32;
  localparam int MAX_ITEMS_DEF = 32;
  localparam int PC_W          = 4;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        start_index;
    logic                    last;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]        sorted_index;
    logic signed [KEY_W-1:0] sorted_key;
    logic                    end_of_list;
  } out_word_t;

  // one entry of the working list: index plus the key it points to
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic signed [KEY_W-1:0] key;
  } ent_t;

  typedef enum logic [4:0] {
    U_NOP,
    U_LOAD,
    U_PRE_RD,
    U_PRE_KEY,
    U_PRE_WR,
    U_SORT_INIT,
    U_PASS_RD,
    U_PASS_LATCH,
    U_SCAN,
    U_SWAP_A,
    U_SWAP_B,
    U_OUT_INIT,
    U_OUT_RD,
    U_OUT_LOAD,
    U_CLEAR
  } uop_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_LAST,
    C_MORE_I,
    C_N_LE_1,
    C_J_LT_N,
    C_MORE_PASS,
    C_OUT_PEND,
    C_I_LT_N
  } cond_t;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_last;
    logic more_i;
    logic n_le_1;
    logic j_lt_n;
    logic more_pass;
    logic out_pend;
    logic i_lt_n;
  } flags_t;

  localparam logic [PC_W-1:0] S_LOAD       = 4'd0;
  localparam logic [PC_W-1:0] S_PRE_RD     = 4'd1;
  localparam logic [PC_W-1:0] S_PRE_KEY    = 4'd2;
  localparam logic [PC_W-1:0] S_PRE_WR     = 4'd3;
  localparam logic [PC_W-1:0] S_SORT_INIT  = 4'd4;
  localparam logic [PC_W-1:0] S_PASS_RD    = 4'd5;
  localparam logic [PC_W-1:0] S_PASS_LATCH = 4'd6;
  localparam logic [PC_W-1:0] S_SCAN       = 4'd7;
  localparam logic [PC_W-1:0] S_SWAP_A     = 4'd8;
  localparam logic [PC_W-1:0] S_SWAP_B     = 4'd9;
  localparam logic [PC_W-1:0] S_OUT_INIT   = 4'd10;
  localparam logic [PC_W-1:0] S_OUT_RD     = 4'd11;
  localparam logic [PC_W-1:0] S_OUT_LOAD   = 4'd12;
  localparam logic [PC_W-1:0] S_OUT_WAIT   = 4'd13;
  localparam logic [PC_W-1:0] S_OUT_NEXT   = 4'd14;
  localparam logic [PC_W-1:0] S_CLEAR      = 4'd15;

  // control store: taken branch goes to target, otherwise step falls through
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{op: U_NOP, cond: C_ALWAYS, target: S_LOAD};
    case (pc)
      S_LOAD:       cw = '{op: U_LOAD,       cond: C_NO_LAST,   target: S_LOAD};
      S_PRE_RD:     cw = '{op: U_PRE_RD,     cond: C_NEVER,     target: S_LOAD};
      S_PRE_KEY:    cw = '{op: U_PRE_KEY,    cond: C_NEVER,     target: S_LOAD};
      S_PRE_WR:     cw = '{op: U_PRE_WR,     cond: C_MORE_I,    target: S_PRE_RD};
      S_SORT_INIT:  cw = '{op: U_SORT_INIT,  cond: C_N_LE_1,    target: S_OUT_INIT};
      S_PASS_RD:    cw = '{op: U_PASS_RD,    cond: C_NEVER,     target: S_LOAD};
      S_PASS_LATCH: cw = '{op: U_PASS_LATCH, cond: C_NEVER,     target: S_LOAD};
      S_SCAN:       cw = '{op: U_SCAN,       cond: C_J_LT_N,    target: S_SCAN};
      S_SWAP_A:     cw = '{op: U_SWAP_A,     cond: C_NEVER,     target: S_LOAD};
      S_SWAP_B:     cw = '{op: U_SWAP_B,     cond: C_MORE_PASS, target: S_PASS_RD};
      S_OUT_INIT:   cw = '{op: U_OUT_INIT,   cond: C_NEVER,     target: S_LOAD};
      S_OUT_RD:     cw = '{op: U_OUT_RD,     cond: C_NEVER,     target: S_LOAD};
      S_OUT_LOAD:   cw = '{op: U_OUT_LOAD,   cond: C_NEVER,     target: S_LOAD};
      S_OUT_WAIT:   cw = '{op: U_NOP,        cond: C_OUT_PEND,  target: S_OUT_WAIT};
      S_OUT_NEXT:   cw = '{op: U_NOP,        cond: C_I_LT_N,    target: S_OUT_RD};
      S_CLEAR:      cw = '{op: U_CLEAR,      cond: C_ALWAYS,    target: S_LOAD};
      default:      cw = '{op: U_NOP,        cond: C_ALWAYS,    target: S_LOAD};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dis_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module dis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dis_useq.sv =====
// microcode sequencer: step counter, control store lookup and branch test
// depends on dis_pkg
`default_nettype none

module dis_useq
  import dis_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire flags_t     flags,
  output ctrl_word_t      ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign ctrl = ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_LAST:   take = flags.no_last;
      C_MORE_I:    take = flags.more_i;
      C_N_LE_1:    take = flags.n_le_1;
      C_J_LT_N:    take = flags.j_lt_n;
      C_MORE_PASS: take = flags.more_pass;
      C_OUT_PEND:  take = flags.out_pend;
      C_I_LT_N:    take = flags.i_lt_n;
      default:     take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/descending_index_selection_sort.sv =====
// top level: load, key prefill, selection sort and readout of an index list
// depends on dis_pkg, dis_ram, dis_useq
`default_nettype none

// channel | dir | handshake               | word
// in_     | in  | in_valid / in_ready     | in_word_t  (key, start_index, last)
// out_    | out | out_valid / out_ready   | out_word_t (sorted_index, sorted_key, end_of_list)
//
// one input word per cycle while loading; after the last word come key prefill,
// the selection sort and readout, all paced by the single read port of the working list ram
// in_ready is low from the last word until the final result is taken and S_CLEAR has run
// out_ready low simply holds the readout step; no word is dropped
// synchronous active-low reset clears the step counter, count and out_valid

module descending_index_selection_sort
  import dis_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;

  ctrl_word_t ctrl;
  flags_t     flags;

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic [CW-1:0]    pick_r, pick_nxt;
  ent_t             pick_ent_r, pick_ent_nxt;
  ent_t             ent_i_r, ent_i_nxt;
  logic [IDX_W-1:0] tmp_idx_r, tmp_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             key_we;
  logic [AW-1:0]    key_waddr;
  logic             key_re;
  logic [AW-1:0]    key_raddr;
  logic [KEY_W-1:0] key_rdata;

  logic             wrk_we;
  logic [AW-1:0]    wrk_waddr;
  ent_t             wrk_wdata;
  logic             wrk_re;
  logic [AW-1:0]    wrk_raddr;
  ent_t             wrk_rdata;

  logic [XW-1:0]    idx_x;
  logic [CW-1:0]    scan_pos;
  logic             in_acc;
  logic             oor;

  dis_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  dis_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ITEMS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_data.key),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  dis_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (MAX_ITEMS)
  ) u_wrk_ram (
    .clk   (clk),
    .we    (wrk_we),
    .waddr (wrk_waddr),
    .wdata (wrk_wdata),
    .re    (wrk_re),
    .raddr (wrk_raddr),
    .rdata (wrk_rdata)
  );

  assign in_ready  = (ctrl.op == U_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign idx_x     = XW'(wrk_rdata.idx);
  assign key_raddr = idx_x[AW-1:0];
  assign scan_pos  = j_r - CW'(1);
  assign oor       = ({{(32-IDX_W){1'b0}}, tmp_idx_r} >= 32'(MAX_ITEMS));

  always_comb begin
    flags.no_last   = !(in_acc && in_data.last);
    flags.more_i    = ({1'b0, i_r} + (CW+1)'(1)) < {1'b0, cnt_r};
    flags.n_le_1    = (cnt_r <= CW'(1));
    flags.j_lt_n    = (j_r < cnt_r);
    flags.more_pass = ({1'b0, i_r} + (CW+1)'(2)) < {1'b0, cnt_r};
    flags.out_pend  = out_valid_r && !out_ready;
    flags.i_lt_n    = (i_r < cnt_r);
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pick_nxt      = pick_r;
    pick_ent_nxt  = pick_ent_r;
    ent_i_nxt     = ent_i_r;
    tmp_idx_nxt   = tmp_idx_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;

    key_we    = 1'b0;
    key_waddr = cnt_r[AW-1:0];
    key_re    = 1'b0;
    wrk_we    = 1'b0;
    wrk_waddr = cnt_r[AW-1:0];
    wrk_wdata = '{idx: in_data.start_index, key: '0};
    wrk_re    = 1'b0;
    wrk_raddr = i_r[AW-1:0];

    case (ctrl.op)
      U_LOAD: begin
        i_nxt = '0;
        if (in_acc && (cnt_r < CW'(MAX_ITEMS))) begin
          key_we  = 1'b1;
          wrk_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      U_PRE_RD: begin
        wrk_re = 1'b1;
      end
      U_PRE_KEY: begin
        tmp_idx_nxt = wrk_rdata.idx;
        key_re      = 1'b1;
      end
      U_PRE_WR: begin
        wrk_we    = 1'b1;
        wrk_waddr = i_r[AW-1:0];
        wrk_wdata = '{idx: tmp_idx_r, key: oor ? '0 : key_rdata};
        i_nxt     = i_r + CW'(1);
      end
      U_SORT_INIT: begin
        i_nxt = '0;
      end
      U_PASS_RD: begin
        wrk_re = 1'b1;
        j_nxt  = i_r + CW'(1);
      end
      U_PASS_LATCH: begin
        ent_i_nxt    = wrk_rdata;
        pick_ent_nxt = wrk_rdata;
        pick_nxt     = i_r;
        wrk_re       = 1'b1;
        wrk_raddr    = j_r[AW-1:0];
        j_nxt        = j_r + CW'(1);
      end
      U_SCAN: begin
        if (wrk_rdata.key > pick_ent_r.key) begin
          pick_ent_nxt = wrk_rdata;
          pick_nxt     = scan_pos;
        end
        if (j_r < cnt_r) begin
          wrk_re    = 1'b1;
          wrk_raddr = j_r[AW-1:0];
          j_nxt     = j_r + CW'(1);
        end
      end
      U_SWAP_A: begin
        wrk_we    = 1'b1;
        wrk_waddr = i_r[AW-1:0];
        wrk_wdata = pick_ent_r;
      end
      U_SWAP_B: begin
        wrk_we    = 1'b1;
        wrk_waddr = pick_r[AW-1:0];
        wrk_wdata = ent_i_r;
        i_nxt     = i_r + CW'(1);
      end
      U_OUT_INIT: begin
        i_nxt = '0;
      end
      U_OUT_RD: begin
        wrk_re = 1'b1;
      end
      U_OUT_LOAD: begin
        out_word_nxt.sorted_index = wrk_rdata.idx;
        out_word_nxt.sorted_key   = wrk_rdata.key;
        out_word_nxt.end_of_list  = ({1'b0, i_r} + (CW+1)'(1)) == {1'b0, cnt_r};
        out_valid_nxt             = 1'b1;
        i_nxt                     = i_r + CW'(1);
      end
      U_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    pick_r     <= pick_nxt;
    pick_ent_r <= pick_ent_nxt;
    ent_i_r    <= ent_i_nxt;
    tmp_idx_r  <= tmp_idx_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/dis_chk.sv =====
// port-level checks for the descending index selection sort, bound to the top level
// depends on dis_pkg and descending_index_selection_sort
`default_nettype none

module dis_chk
  import dis_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // no loading while results are shown
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // last input word closes the load window
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last |=> !in_ready)
    else $error("input still open after last word");

  // nothing follows the end of the list
  a_end_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.end_of_list |=> !out_valid)
    else $error("result after end of list");

endmodule

bind descending_index_selection_sort dis_chk u_dis_chk (.*);

`default_nettype wire
